>>> rtl/zfhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfhp_pkg
// Shared types and constants for the zcl frame header parser.
// ----------------------------------------------------------------------------
package zfhp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 9;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [CountW-1:0] CountMax = 9'd256;
  localparam logic [2:0]        HdrShort = 3'd3;
  localparam logic [2:0]        HdrLong  = 3'd5;
  localparam logic [7:0]        MaskReserved = 8'he0;
  localparam logic [4:0]        MaskFlags    = 5'h1c;
  localparam int unsigned       FlagMfrBit   = 2;

  localparam logic [ByteW-1:0]  MaxBodyLenReset = 8'd127;

  // register index taken from paddr bit 2
  localparam logic RegMaxBodyLength = 1'b0;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_LONG    = 3'd1,
    ST_TRUNCATED   = 3'd2,
    ST_BAD_TYPE    = 3'd3,
    ST_BAD_LAYOUT  = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [1:0]  frame_type;
    logic [4:0]  header_flags;
    logic [7:0]  reserved_control_bits;
    logic [15:0] vendor_code;
    logic [7:0]  sequence_number;
    logic [7:0]  command_identifier;
    logic [2:0]  app_offset;
    logic [7:0]  app_length;
  } result_t;

endpackage

>>> rtl/zfhp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfhp_in_reg
// Input register stage for body bytes, stalls only when it cannot move on.
// ----------------------------------------------------------------------------
module zfhp_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [zfhp_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_byte_i,
  output logic                      stall_o,
  input  logic                      advance_i,
  output logic                      valid_o,
  output logic [zfhp_pkg::ByteW-1:0] data_byte_o,
  output logic                      last_byte_o
);
  import zfhp_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic             load;

  assign stall_o = valid_q && !advance_i;
  assign load    = valid_i && !stall_o;
  assign valid_d = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign valid_o     = valid_q;
  assign data_byte_o = byte_q;
  assign last_byte_o = last_q;

endmodule

>>> rtl/zfhp_frame_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfhp_frame_state
// Byte counter and header capture registers, with the end-of-body decode.
// ----------------------------------------------------------------------------
module zfhp_frame_state (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [zfhp_pkg::ByteW-1:0] data_byte_i,
  input  logic                       last_byte_i,
  input  logic [zfhp_pkg::ByteW-1:0] max_body_length_i,
  output zfhp_pkg::result_t          result_o
);
  import zfhp_pkg::*;

  logic [CountW-1:0] count_q, count_d, count_n;
  logic [7:0]        ctrl_q, ctrl_d, ctrl_n;
  logic [15:0]       mfr_q, mfr_d, mfr_n;
  logic [7:0]        seq_q, seq_d, seq_n;
  logic [7:0]        cmd_q, cmd_d, cmd_n;
  logic              mfr_old, mfr;
  logic [2:0]        size;
  status_e           status;

  // header byte capture by position
  always_comb begin
    mfr_old = ctrl_q[FlagMfrBit];
    ctrl_n  = ctrl_q;
    mfr_n   = mfr_q;
    seq_n   = seq_q;
    cmd_n   = cmd_q;
    if (count_q == '0) begin
      ctrl_n = data_byte_i;
    end else if (mfr_old) begin
      case (count_q)
        9'd1:    mfr_n[7:0]  = data_byte_i;
        9'd2:    mfr_n[15:8] = data_byte_i;
        9'd3:    seq_n       = data_byte_i;
        9'd4:    cmd_n       = data_byte_i;
        default: ;
      endcase
    end else begin
      case (count_q)
        9'd1:    seq_n = data_byte_i;
        9'd2:    cmd_n = data_byte_i;
        default: ;
      endcase
    end
    count_n = (count_q == CountMax) ? count_q : count_q + 1'b1;
  end

  always_comb begin
    mfr  = ctrl_n[FlagMfrBit];
    size = mfr ? HdrLong : HdrShort;
    if (count_n > {1'b0, max_body_length_i}) begin
      status = ST_TOO_LONG;
    end else if (ctrl_n[1:0] > 2'd1) begin
      status = ST_BAD_TYPE;
    end else if (mfr && ((ctrl_n & MaskReserved) != 8'd0)) begin
      status = ST_BAD_LAYOUT;
    end else if (count_n < {6'd0, size}) begin
      status = ST_TRUNCATED;
    end else begin
      status = ST_OK;
    end

    result_o        = '0;
    result_o.status = status;
    if (status == ST_OK) begin
      result_o.frame_type            = ctrl_n[1:0];
      result_o.header_flags          = ctrl_n[4:0] & MaskFlags;
      result_o.reserved_control_bits = ctrl_n & MaskReserved;
      result_o.vendor_code           = mfr ? mfr_n : 16'd0;
      result_o.sequence_number       = seq_n;
      result_o.command_identifier    = cmd_n;
      result_o.app_offset            = size;
      result_o.app_length            = count_n[7:0] - {5'd0, size};
    end
  end

  always_comb begin
    count_d = count_q;
    ctrl_d  = ctrl_q;
    mfr_d   = mfr_q;
    seq_d   = seq_q;
    cmd_d   = cmd_q;
    if (fire_i) begin
      if (last_byte_i) begin
        count_d = '0;
        ctrl_d  = '0;
        mfr_d   = '0;
        seq_d   = '0;
        cmd_d   = '0;
      end else begin
        count_d = count_n;
        ctrl_d  = ctrl_n;
        mfr_d   = mfr_n;
        seq_d   = seq_n;
        cmd_d   = cmd_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ctrl_q  <= '0;
      mfr_q   <= '0;
      seq_q   <= '0;
      cmd_q   <= '0;
    end else begin
      count_q <= count_d;
      ctrl_q  <= ctrl_d;
      mfr_q   <= mfr_d;
      seq_q   <= seq_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule

>>> rtl/zfhp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfhp_out_reg
// Result register holding one decoded header word until it is taken.
// ----------------------------------------------------------------------------
module zfhp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  zfhp_pkg::result_t result_i,
  input  logic              stall_i,
  output logic              valid_o,
  output zfhp_pkg::result_t result_o
);
  import zfhp_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

>>> rtl/zcl_frame_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcl_frame_header_parser
// Zigbee cluster-library frame header decoder, one body byte per word.
// output: the last byte passes the input register, then the result register, before out_valid_o
// throughput: one byte per cycle; only a stalled result with a last byte behind it
//   holds the input stage
// reset: asynchronous, active low; clears frame state, valid flags, and sets
//   max_body_length to 127
// ----------------------------------------------------------------------------
module zcl_frame_header_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // apb configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [zfhp_pkg::AddrW-1:0]  paddr,
  input  logic [zfhp_pkg::DataW-1:0]  pwdata,
  output logic [zfhp_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  // byte input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [1:0]                  frame_type_o,
  output logic [4:0]                  header_flags_o,
  output logic [7:0]                  reserved_control_bits_o,
  output logic [15:0]                 vendor_code_o,
  output logic [7:0]                  sequence_number_o,
  output logic [7:0]                  command_identifier_o,
  output logic [2:0]                  app_offset_o,
  output logic [7:0]                  app_length_o
);
  import zfhp_pkg::*;

  logic             max_len_we;
  logic [ByteW-1:0] max_len_q, max_len_d;
  logic             s1_valid, s1_last, advance, fire;
  logic [ByteW-1:0] s1_byte;
  result_t          res_comb, res_q;

  // configuration register
  assign pready     = 1'b1;
  assign max_len_we = psel && penable && pwrite && (paddr[AddrW-1] == RegMaxBodyLength);
  assign max_len_d  = max_len_we ? pwdata[ByteW-1:0] : max_len_q;
  assign prdata     = (paddr[AddrW-1] == RegMaxBodyLength) ?
                      {{(DataW-ByteW){1'b0}}, max_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxBodyLenReset;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  // non-last bytes never wait on the output side
  assign advance = !s1_last || !out_valid_o || !out_stall_i;
  assign fire    = s1_valid && advance;

  zfhp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .stall_o     (in_stall_o),
    .advance_i   (advance),
    .valid_o     (s1_valid),
    .data_byte_o (s1_byte),
    .last_byte_o (s1_last)
  );

  zfhp_frame_state u_frame_state (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (fire),
    .data_byte_i       (s1_byte),
    .last_byte_i       (s1_last),
    .max_body_length_i (max_len_q),
    .result_o          (res_comb)
  );

  zfhp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && s1_last),
    .result_i (res_comb),
    .stall_i  (out_stall_i),
    .valid_o  (out_valid_o),
    .result_o (res_q)
  );

  assign status_o                = res_q.status;
  assign frame_type_o            = res_q.frame_type;
  assign header_flags_o          = res_q.header_flags;
  assign reserved_control_bits_o = res_q.reserved_control_bits;
  assign vendor_code_o           = res_q.vendor_code;
  assign sequence_number_o       = res_q.sequence_number;
  assign command_identifier_o    = res_q.command_identifier;
  assign app_offset_o            = res_q.app_offset;
  assign app_length_o            = res_q.app_length;

  a_ok_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |->
      (app_offset_o == HdrShort || app_offset_o == HdrLong))
    else $error("ok result with bad payload offset");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (app_offset_o == 3'd0 && vendor_code_o == 16'd0 && app_length_o == 8'd0))
    else $error("error result carries header fields");

  a_long_hdr_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |->
      (header_flags_o[FlagMfrBit] == (app_offset_o == HdrLong)))
    else $error("header size does not match manufacturer flag");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && s1_last && out_valid_o))
    else $error("input stalled without a pending result");

endmodule
